// ----- hw/rtl/irpwt_pkg.sv -----
// Shared types and constants for the pulse-width IR transmitter.
// No dependencies; every other file of the block imports this package.
package irpwt_pkg;

    localparam int MESSAGE_W    = 7;
    localparam int UNIT_W       = 16;
    localparam int CMP_W        = 8;
    localparam int SEG_COUNT_W  = UNIT_W + 2;  // four units of the widest unit

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RST  = 16'd4800;
    localparam logic [CMP_W-1:0]  CARRIER_CMP_RST = 8'd104;

    // Register indexes on the configuration port
    localparam logic REG_UNIT_TICKS  = 1'b0;
    localparam logic REG_CARRIER_CMP = 1'b1;

    typedef struct packed {
        logic [UNIT_W-1:0] unit_ticks;
        logic [CMP_W-1:0]  carrier_compare;
    } t_cfg;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } t_result;

endpackage

// ----- hw/rtl/irpwt_cfg_regs.sv -----
// APB-style configuration registers: unit length and carrier compare.
// Depends on irpwt_pkg.
module irpwt_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output irpwt_pkg::t_cfg    o_cfg
);
    import irpwt_pkg::*;

    logic [UNIT_W-1:0] r_unit_ticks;
    logic [CMP_W-1:0]  r_carrier_cmp;
    logic              w_reg_index;
    logic              w_write;

    assign pready      = 1'b1;
    assign w_reg_index = paddr[2];
    assign w_write     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= UNIT_TICKS_RST;
            r_carrier_cmp <= CARRIER_CMP_RST;
        end else if (w_write) begin
            unique case (w_reg_index)
                REG_UNIT_TICKS:  r_unit_ticks  <= pwdata[UNIT_W-1:0];
                REG_CARRIER_CMP: r_carrier_cmp <= pwdata[CMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_index)
            REG_UNIT_TICKS:  prdata = {{(32-UNIT_W){1'b0}}, r_unit_ticks};
            REG_CARRIER_CMP: prdata = {{(32-CMP_W){1'b0}}, r_carrier_cmp};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.unit_ticks      = r_unit_ticks;
    assign o_cfg.carrier_compare = r_carrier_cmp;

endmodule

// ----- hw/rtl/irpwt_frame_gen.sv -----
// Frame state and per-transaction next-state logic: segment sequencing,
// mark/space timing and carrier generation. Depends on irpwt_pkg.
module irpwt_frame_gen #(
    parameter int COMMAND_BITS = 7,
    parameter int ADDRESS_BITS = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic                              i_req_type,
    input  logic [irpwt_pkg::MESSAGE_W-1:0]   i_message,
    input  irpwt_pkg::t_cfg                   i_cfg,
    output irpwt_pkg::t_result                o_result
);
    import irpwt_pkg::*;

    localparam int SEG_TOTAL = 2 * (1 + COMMAND_BITS + ADDRESS_BITS);
    localparam int SEG_W     = $clog2(SEG_TOTAL);

    logic                   r_active,     n_active;
    logic [SEG_W-1:0]       r_seg_idx,    n_seg_idx;
    logic [SEG_COUNT_W-1:0] r_seg_cnt,    n_seg_cnt;
    logic [CMP_W-1:0]       r_car_cnt,    n_car_cnt;
    logic                   r_car_lvl,    n_car_lvl;
    logic [COMMAND_BITS-1:0] r_cmd,       n_cmd;

    logic [COMMAND_BITS+MESSAGE_W-1:0] w_msg_wide;
    logic [UNIT_W-1:0]      w_unit;
    logic [SEG_COUNT_W-1:0] w_len;
    logic [SEG_COUNT_W-1:0] w_seg_inc;
    logic [CMP_W:0]         w_car_inc;
    logic [SEG_W:0]         w_idx_inc;
    logic                   w_mark;
    logic                   w_start_sym;
    logic                   w_accepted;
    logic                   w_done;

    assign w_msg_wide  = {{COMMAND_BITS{1'b0}}, i_message};
    assign w_unit      = (i_cfg.unit_ticks == '0) ? UNIT_W'(1) : i_cfg.unit_ticks;
    assign w_mark      = ~r_seg_idx[0];
    assign w_start_sym = (r_seg_idx[SEG_W-1:1] == '0);

    // Command bits shift out as their marks end, so zeros follow for the address
    always_comb begin
        if (!w_mark) begin
            w_len = {2'b00, w_unit};
        end else if (w_start_sym) begin
            w_len = {w_unit, 2'b00};
        end else if (r_cmd[0]) begin
            w_len = {1'b0, w_unit, 1'b0};
        end else begin
            w_len = {2'b00, w_unit};
        end
    end

    assign w_seg_inc = r_seg_cnt + SEG_COUNT_W'(1);
    assign w_car_inc = {1'b0, r_car_cnt} + (CMP_W+1)'(1);
    assign w_idx_inc = {1'b0, r_seg_idx} + (SEG_W+1)'(1);

    always_comb begin
        n_active   = r_active;
        n_seg_idx  = r_seg_idx;
        n_seg_cnt  = r_seg_cnt;
        n_car_cnt  = r_car_cnt;
        n_car_lvl  = r_car_lvl;
        n_cmd      = r_cmd;
        w_accepted = 1'b0;
        w_done     = 1'b0;

        if (i_req_type) begin
            // a request while busy is refused and leaves the state alone
            if (!r_active) begin
                n_cmd      = w_msg_wide[COMMAND_BITS-1:0];
                n_active   = 1'b1;
                n_seg_idx  = '0;
                n_seg_cnt  = '0;
                n_car_cnt  = '0;
                n_car_lvl  = 1'b0;
                w_accepted = 1'b1;
            end
        end else if (r_active) begin
            n_seg_cnt = w_seg_inc;
            if (w_mark) begin
                if (w_car_inc >= ({1'b0, i_cfg.carrier_compare} + (CMP_W+1)'(1))) begin
                    n_car_cnt = '0;
                    n_car_lvl = ~r_car_lvl;
                end else begin
                    n_car_cnt = w_car_inc[CMP_W-1:0];
                end
            end
            if (w_seg_inc >= w_len) begin
                n_seg_cnt = '0;
                n_car_cnt = '0;
                n_car_lvl = 1'b0;
                if (w_mark && !w_start_sym) begin
                    n_cmd = r_cmd >> 1;
                end
                if (w_idx_inc >= (SEG_W+1)'(SEG_TOTAL)) begin
                    n_active  = 1'b0;
                    n_seg_idx = '0;
                    w_done    = 1'b1;
                end else begin
                    n_seg_idx = w_idx_inc[SEG_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_seg_idx <= '0;
            r_seg_cnt <= '0;
            r_car_cnt <= '0;
            r_car_lvl <= 1'b0;
            r_cmd     <= '0;
        end else if (i_fire) begin
            r_active  <= n_active;
            r_seg_idx <= n_seg_idx;
            r_seg_cnt <= n_seg_cnt;
            r_car_cnt <= n_car_cnt;
            r_car_lvl <= n_car_lvl;
            r_cmd     <= n_cmd;
        end
    end

    assign o_result.ir_level   = n_active & ~n_seg_idx[0] & n_car_lvl;
    assign o_result.busy_res   = n_active;
    assign o_result.accepted   = w_accepted;
    assign o_result.frame_done = w_done;

endmodule

// ----- hw/rtl/irpwt_out_stage.sv -----
// Result register with a skid stage so the input side keeps moving while
// a finished result waits. Depends on irpwt_pkg.
module irpwt_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  irpwt_pkg::t_result i_result,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output irpwt_pkg::t_result o_result
);
    import irpwt_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_out_fire;
    logic    w_out_free;

    assign w_out_fire = r_out_valid & ~i_stall;
    assign w_out_free = ~r_out_valid | w_out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_skid_valid | i_fire;
            end
            if (r_skid_valid && w_out_free) begin
                r_skid_valid <= 1'b0;
            end else if (i_fire && !w_out_free) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload: drain the skid first, else take the new transaction
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_fire) begin
                r_out <= i_result;
            end
        end
        if (i_fire && !w_out_free) begin
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- hw/rtl/ir_pulse_width_transmitter.sv -----
// Pulse-width IR frame transmitter, one timer tick or send request per transaction.
// Results are registered, via the skid stage when the output stalls.
// Throughput: one transaction per cycle; the frame state updates in a single pass.
// Input stalls only while the skid stage holds a result the output side has not taken.
// Reset (synchronous, active low) returns to idle and loads the default
// unit length and carrier compare; no clearing pass is needed.
module ir_pulse_width_transmitter #(
    parameter int COMMAND_BITS = 7,
    parameter int ADDRESS_BITS = 5
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic [irpwt_pkg::MESSAGE_W-1:0]  i_message,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_ir_level,
    output logic                             o_busy_res,
    output logic                             o_accepted,
    output logic                             o_frame_done,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import irpwt_pkg::*;

    t_cfg    w_cfg;
    t_result w_next_result;
    t_result w_out_result;
    logic    w_full;
    logic    w_in_fire;

    assign o_stall   = w_full;
    assign w_in_fire = i_valid & ~w_full;

    irpwt_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    irpwt_frame_gen #(
        .COMMAND_BITS (COMMAND_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_frame_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_in_fire),
        .i_req_type (i_req_type),
        .i_message  (i_message),
        .i_cfg      (w_cfg),
        .o_result   (w_next_result)
    );

    irpwt_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_in_fire),
        .i_result (w_next_result),
        .o_full   (w_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (w_out_result)
    );

    assign o_ir_level   = w_out_result.ir_level;
    assign o_busy_res   = w_out_result.busy_res;
    assign o_accepted   = w_out_result.accepted;
    assign o_frame_done = w_out_result.frame_done;

endmodule
